// ===== design/tcce_pkg.sv =====
// Shared constants, types and command codes for the text console cursor engine.
// No dependencies; every other design file depends on this package.
`default_nettype none

package tcce_pkg;

    // Console geometry
    localparam int CONSOLES     = 4;
    localparam int COLUMNS      = 80;
    localparam int SCREEN_ROWS  = 25;
    localparam int REGION_ROWS  = 50;
    localparam int REGION_CELLS = COLUMNS * REGION_ROWS;

    // Field widths
    localparam int CMD_W  = 2;
    localparam int CON_W  = 2;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int ADDR_W = 14;

    // Internal widths
    localparam int ROW_W  = $clog2(REGION_ROWS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int CELL_W = $clog2(CONSOLES * REGION_CELLS);
    localparam int SUM_W  = $clog2(REGION_ROWS + SCREEN_ROWS + 1);

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(REGION_ROWS - 1);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);

    // Command queue between front and back; depth is a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [ATTR_W-1:0] ATTR_RESET     = 8'd7;
    localparam logic [CHAR_W-1:0] NEWLINE_BYTE   = 8'd10;
    localparam logic [CHAR_W-1:0] BACKSPACE_BYTE = 8'd8;
    localparam logic [CHAR_W-1:0] BLANK_BYTE     = 8'd32;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT         = 2'd0,
        CMD_SCROLL_UP   = 2'd1,
        CMD_SCROLL_DOWN = 2'd2,
        CMD_SELECT      = 2'd3
    } t_cmd;

    // Classified operation handed from front to back
    typedef enum logic [2:0] {
        OP_NONE        = 3'd0,
        OP_NEWLINE     = 3'd1,
        OP_BACKSPACE   = 3'd2,
        OP_PRINT       = 3'd3,
        OP_SCROLL_UP   = 3'd4,
        OP_SCROLL_DOWN = 3'd5,
        OP_SELECT      = 3'd6
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [CON_W-1:0]  console;
        logic [CHAR_W-1:0] ch;
    } t_qitem;

endpackage

`default_nettype wire

// ===== design/tcce_if.sv =====
// Handshake interfaces for the command and result channels.
// Depends on tcce_pkg for field widths.
`default_nettype none

interface tcce_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [tcce_pkg::CMD_W-1:0]  command;
    logic [tcce_pkg::CON_W-1:0]  console;
    logic [tcce_pkg::CHAR_W-1:0] ch;

    modport source (output valid, command, console, ch, input ready);
    modport sink   (input valid, command, console, ch, output ready);
endinterface

interface tcce_res_if;
    logic                       valid;
    logic                       ready;
    logic                       mem_write;
    logic [tcce_pkg::ADDR_W-1:0] mem_addr;
    logic [tcce_pkg::CHAR_W-1:0] mem_char;
    logic [tcce_pkg::ATTR_W-1:0] mem_attr;
    logic                       display_update;
    logic [tcce_pkg::ADDR_W-1:0] cursor_pos;
    logic [tcce_pkg::ADDR_W-1:0] start_addr;
    logic [tcce_pkg::CON_W-1:0]  shown_console;

    modport source (output valid, mem_write, mem_addr, mem_char, mem_attr, display_update,
                    cursor_pos, start_addr, shown_console, input ready);
    modport sink   (input valid, mem_write, mem_addr, mem_char, mem_attr, display_update,
                    cursor_pos, start_addr, shown_console, output ready);
endinterface

`default_nettype wire

// ===== design/tcce_front.sv =====
// Front end: accepts commands and classifies them into operations for the queue.
// Depends on tcce_pkg and tcce_cmd_if.
`default_nettype none

module tcce_front (
    tcce_cmd_if.sink              i_cmd,
    input  logic                  i_space,
    output logic                  o_push,
    output tcce_pkg::t_qitem      o_item
);
    import tcce_pkg::*;

    logic con_ok;
    t_op  op;

    assign con_ok = {1'b0, i_cmd.console} < (CON_W + 1)'(CONSOLES);

    always_comb begin
        op = OP_NONE;
        if (con_ok) begin
            unique case (t_cmd'(i_cmd.command))
                CMD_PUT: begin
                    if (i_cmd.ch == NEWLINE_BYTE) begin
                        op = OP_NEWLINE;
                    end else if (i_cmd.ch == BACKSPACE_BYTE) begin
                        op = OP_BACKSPACE;
                    end else begin
                        op = OP_PRINT;
                    end
                end
                CMD_SCROLL_UP:   op = OP_SCROLL_UP;
                CMD_SCROLL_DOWN: op = OP_SCROLL_DOWN;
                CMD_SELECT:      op = OP_SELECT;
                default:         op = OP_NONE;
            endcase
        end
    end

    assign i_cmd.ready    = i_space;
    assign o_push         = i_cmd.valid && i_space;
    assign o_item.op      = op;
    assign o_item.console = i_cmd.console;
    assign o_item.ch      = i_cmd.ch;

endmodule

`default_nettype wire

// ===== design/tcce_queue.sv =====
// Short register queue that decouples the command front end from the back end.
// Depends on tcce_pkg.
`default_nettype none

module tcce_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tcce_pkg::t_qitem i_item,
    output logic             o_space,
    output logic             o_valid,
    output tcce_pkg::t_qitem o_item,
    input  logic             i_pop
);
    import tcce_pkg::*;

    t_qitem             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wptr, r_rptr;
    logic [QCNT_W-1:0]  r_count;

    assign o_space = r_count != QCNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_space)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue pop while empty");
`endif

endmodule

`default_nettype wire

// ===== design/tcce_back.sv =====
// Back end: per-console cursor and view state, cell write generation, result register.
// Depends on tcce_pkg and tcce_res_if.
`default_nettype none

module tcce_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  tcce_pkg::t_qitem            i_item,
    output logic                        o_pop,
    input  logic                        i_cfg_we,
    input  logic [tcce_pkg::ATTR_W-1:0] i_cfg_wdata,
    tcce_res_if.source                  o_res
);
    import tcce_pkg::*;

    typedef struct packed {
        logic              mem_write;
        logic [ADDR_W-1:0] mem_addr;
        logic [CHAR_W-1:0] mem_char;
        logic [ATTR_W-1:0] mem_attr;
        logic              display_update;
        logic [ADDR_W-1:0] cursor_pos;
        logic [ADDR_W-1:0] start_addr;
        logic [CON_W-1:0]  shown_console;
    } t_result;

    // Per-console state, stored as row/column so no division is needed
    logic [ROW_W-1:0]  r_row  [CONSOLES];
    logic [COL_W-1:0]  r_col  [CONSOLES];
    logic [ROW_W-1:0]  r_srow [CONSOLES];
    logic [CON_W-1:0]  r_cur_con, n_cur_con;
    logic [CELL_W-1:0] r_disp_cur, n_disp_cur;
    logic [CELL_W-1:0] r_disp_st, n_disp_st;
    logic [ATTR_W-1:0] r_attr;
    logic              r_out_valid;
    t_result           r_out, n_out;

    logic [CON_W-1:0]  idx;
    logic [ROW_W-1:0]  e_row, e_srow, n_row, n_srow, w_row;
    logic [COL_W-1:0]  e_col, n_col, w_col;
    logic              wr, upd, is_put;
    logic [CHAR_W-1:0] w_char;
    logic [CELL_W-1:0] base, w_cell, cur_cell, st_cell;

    assign o_pop = i_valid && (!r_out_valid || o_res.ready);
    assign idx   = i_item.console;
    assign e_row  = r_row[idx];
    assign e_col  = r_col[idx];
    assign e_srow = r_srow[idx];

    always_comb begin
        n_row     = e_row;
        n_col     = e_col;
        n_srow    = e_srow;
        w_row     = e_row;
        w_col     = e_col;
        wr        = 1'b0;
        w_char    = '0;
        upd       = 1'b0;
        is_put    = 1'b0;
        n_cur_con = r_cur_con;
        unique case (i_item.op)
            OP_NEWLINE: begin
                is_put = 1'b1;
                if (e_row != LAST_ROW) begin
                    n_row = e_row + ROW_W'(1);
                    n_col = '0;
                end
            end
            OP_BACKSPACE: begin
                is_put = 1'b1;
                if (e_row != '0 || e_col != '0) begin
                    if (e_col == '0) begin
                        n_row = e_row - ROW_W'(1);
                        n_col = LAST_COL;
                    end else begin
                        n_col = e_col - COL_W'(1);
                    end
                    wr     = 1'b1;
                    w_char = BLANK_BYTE;
                    w_row  = n_row;
                    w_col  = n_col;
                end
            end
            OP_PRINT: begin
                is_put = 1'b1;
                if (e_row != LAST_ROW || e_col != LAST_COL) begin
                    wr     = 1'b1;
                    w_char = i_item.ch;
                    if (e_col == LAST_COL) begin
                        n_row = e_row + ROW_W'(1);
                        n_col = '0;
                    end else begin
                        n_col = e_col + COL_W'(1);
                    end
                end
            end
            OP_SCROLL_UP: begin
                if (e_srow != '0) begin
                    n_srow = e_srow - ROW_W'(1);
                end
                upd = idx == r_cur_con;
            end
            OP_SCROLL_DOWN: begin
                if (SUM_W'(e_srow) + SUM_W'(SCREEN_ROWS) < SUM_W'(REGION_ROWS)) begin
                    n_srow = e_srow + ROW_W'(1);
                end
                upd = idx == r_cur_con;
            end
            OP_SELECT: begin
                n_cur_con = idx;
                upd       = 1'b1;
            end
            default: begin
                upd = 1'b0;
            end
        endcase
        if (is_put) begin
            // pull the view down so the cursor row is its last row
            if (SUM_W'(n_row) >= SUM_W'(e_srow) + SUM_W'(SCREEN_ROWS)) begin
                n_srow = ROW_W'(SUM_W'(n_row) + SUM_W'(1) - SUM_W'(SCREEN_ROWS));
            end
            upd = idx == r_cur_con;
        end
    end

    always_comb begin
        base     = CELL_W'(idx) * CELL_W'(REGION_CELLS);
        w_cell   = base + CELL_W'(w_row) * CELL_W'(COLUMNS) + CELL_W'(w_col);
        cur_cell = base + CELL_W'(n_row) * CELL_W'(COLUMNS) + CELL_W'(n_col);
        st_cell  = base + CELL_W'(n_srow) * CELL_W'(COLUMNS);

        n_disp_cur = upd ? cur_cell : r_disp_cur;
        n_disp_st  = upd ? st_cell : r_disp_st;

        n_out.mem_write      = wr;
        n_out.mem_addr       = wr ? ADDR_W'(w_cell) : '0;
        n_out.mem_char       = wr ? w_char : '0;
        n_out.mem_attr       = wr ? r_attr : '0;
        n_out.display_update = upd;
        n_out.cursor_pos     = ADDR_W'(n_disp_cur);
        n_out.start_addr     = ADDR_W'(n_disp_st);
        n_out.shown_console  = n_cur_con;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CONSOLES; c++) begin
                r_row[c]  <= '0;
                r_col[c]  <= '0;
                r_srow[c] <= '0;
            end
            r_cur_con   <= '0;
            r_disp_cur  <= '0;
            r_disp_st   <= '0;
            r_attr      <= ATTR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_attr <= i_cfg_wdata;
            end
            if (o_pop) begin
                r_row[idx]  <= n_row;
                r_col[idx]  <= n_col;
                r_srow[idx] <= n_srow;
                r_cur_con   <= n_cur_con;
                r_disp_cur  <= n_disp_cur;
                r_disp_st   <= n_disp_st;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.mem_write      = r_out.mem_write;
    assign o_res.mem_addr       = r_out.mem_addr;
    assign o_res.mem_char       = r_out.mem_char;
    assign o_res.mem_attr       = r_out.mem_attr;
    assign o_res.display_update = r_out.display_update;
    assign o_res.cursor_pos     = r_out.cursor_pos;
    assign o_res.start_addr     = r_out.start_addr;
    assign o_res.shown_console  = r_out.shown_console;

`ifndef SYNTH
    a_idle_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.mem_write) |->
        (o_res.mem_addr == '0 && o_res.mem_char == '0 && o_res.mem_attr == '0))
        else $error("write fields not cleared without a cell write");

    a_cursor_in_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row[0] <= LAST_ROW && r_col[0] <= LAST_COL)
        else $error("cursor left its region");

    a_view_in_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_srow[0] == '0 || SUM_W'(r_srow[0]) + SUM_W'(SCREEN_ROWS) <= SUM_W'(REGION_ROWS))
        else $error("view left its region");

    a_select_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_item.op == OP_SELECT) |=> r_cur_con == $past(i_item.console))
        else $error("console select not applied");
`endif

endmodule

`default_nettype wire

// ===== design/text_console_cursor_engine_unit.sv =====
// Top level of the text console cursor engine: front end, queue, back end.
// Depends on tcce_pkg, tcce_if, tcce_front, tcce_queue and tcce_back.
//
// Usage:
//   i_cmd carries commands (put character, scroll up, scroll down, select
//   console) with valid/ready; o_res returns exactly one result per command:
//   an optional video memory cell write plus the shown console's cursor cell,
//   view start cell and index. i_cfg_we/i_cfg_wdata write the attribute byte
//   used for printed and erased cells; write it only while the block is idle.
//   Path: an accepted command is registered in the queue, then executed by the
//   back end once the result register is free or being read, and its result is
//   held in the result register until o_res.ready takes it.
//   Throughput: one command per cycle while o_res.ready stays high; the back
//   end's update of the per-console cursor state for each command sets this rate.
//   Reset (synchronous, active low): every console's cursor and view sit at
//   the start of its region, console 0 is shown, the attribute is 7, the
//   queue and result register are empty.
//   Receiver stall: the result register holds, the back end stops, the
//   two-entry queue fills and then i_cmd.ready drops.
`default_nettype none

module text_console_cursor_engine_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    tcce_cmd_if.sink                    i_cmd,
    tcce_res_if.source                  o_res,
    input  logic                        i_cfg_we,
    input  logic [tcce_pkg::ATTR_W-1:0] i_cfg_wdata
);
    import tcce_pkg::*;

    logic   push, space, q_valid, pop;
    t_qitem push_item, q_item;

    tcce_front u_front (
        .i_cmd   (i_cmd),
        .i_space (space),
        .o_push  (push),
        .o_item  (push_item)
    );

    tcce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_space (space),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (pop)
    );

    tcce_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_item      (q_item),
        .o_pop       (pop),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

// ===== verif/text_console_cursor_engine_unit_tb.sv =====
// Self-checking testbench for text_console_cursor_engine_unit: directed table, then
// random command bursts under several attribute settings, with random idling on both sides.
// Depends on tcce_pkg and the tcce_cmd_if / tcce_res_if interfaces of the design.

module text_console_cursor_engine_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcce_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int SCREEN_CELLS  = COLUMNS * SCREEN_ROWS;
    localparam int PHASES        = 5;
    localparam int PHASE_ITEMS   = 375;
    localparam int DIRECTED_ROWS = 25;
    localparam int HOLD_AT       = 500;
    localparam int HOLD_CYCLES   = 60;
    localparam int STALL_LIMIT   = 2000;
    localparam int MAX_GAP       = 6;

    typedef struct packed {
        logic              mem_write;
        logic [ADDR_W-1:0] mem_addr;
        logic [CHAR_W-1:0] mem_char;
        logic [ATTR_W-1:0] mem_attr;
        logic              display_update;
        logic [ADDR_W-1:0] cursor_pos;
        logic [ADDR_W-1:0] start_addr;
        logic [CON_W-1:0]  shown_console;
    } t_res;

    typedef struct packed {
        t_cmd              cmd;
        logic [CON_W-1:0]  con;
        logic [CHAR_W-1:0] ch;
        logic              typed;
        t_res              want;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [ATTR_W-1:0] i_cfg_wdata;

    tcce_cmd_if cmd_if ();
    tcce_res_if res_if ();

    text_console_cursor_engine_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Predicted console state
    int unsigned       cursor_cell [CONSOLES];
    int unsigned       view_start [CONSOLES];
    logic [CON_W-1:0]  shown_con;
    logic [ATTR_W-1:0] attr_byte;

    t_res pending_cell_updates [$];
    bit   no_idle;
    int   items_sent;
    int   results_seen;
    int   cells_written;
    int   clamped_cmds;
    int   mismatches;

    t_dir_row directed_rows [DIRECTED_ROWS];

    function automatic t_res apply_console_cmd(t_cmd cmd, logic [CON_W-1:0] con,
                                               logic [CHAR_W-1:0] ch);
        t_res        r;
        int unsigned base;
        int unsigned stop;
        int unsigned cur;
        int unsigned st;
        int unsigned row;
        r = '0;
        if (con < CONSOLES) begin
            base = con * REGION_CELLS;
            stop = base + REGION_CELLS;
            cur  = cursor_cell[con];
            st   = view_start[con];
            case (cmd)
                CMD_PUT: begin
                    if (ch == NEWLINE_BYTE) begin
                        if (cur + COLUMNS < stop)
                            cur = base + COLUMNS * ((cur - base) / COLUMNS + 1);
                        else
                            clamped_cmds++;
                    end else if (ch == BACKSPACE_BYTE) begin
                        if (cur > base) begin
                            cur--;
                            r.mem_write = 1'b1;
                            r.mem_addr  = ADDR_W'(cur);
                            r.mem_char  = BLANK_BYTE;
                            r.mem_attr  = attr_byte;
                        end else begin
                            clamped_cmds++;
                        end
                    end else if (cur + 1 < stop) begin
                        r.mem_write = 1'b1;
                        r.mem_addr  = ADDR_W'(cur);
                        r.mem_char  = ch;
                        r.mem_attr  = attr_byte;
                        cur++;
                    end else begin
                        clamped_cmds++;
                    end
                    // pull the view down so the cursor row is its last row
                    if (cur >= st + SCREEN_CELLS) begin
                        row = (cur - base) / COLUMNS;
                        st  = base + (row + 1 - SCREEN_ROWS) * COLUMNS;
                    end
                    cursor_cell[con] = cur;
                    view_start[con]  = st;
                    r.display_update = (con == shown_con);
                end
                CMD_SCROLL_UP: begin
                    if (st > base) st -= COLUMNS;
                    else clamped_cmds++;
                    view_start[con]  = st;
                    r.display_update = (con == shown_con);
                end
                CMD_SCROLL_DOWN: begin
                    if (st + SCREEN_CELLS < stop) st += COLUMNS;
                    else clamped_cmds++;
                    view_start[con]  = st;
                    r.display_update = (con == shown_con);
                end
                default: begin
                    shown_con        = con;
                    r.display_update = 1'b1;
                end
            endcase
        end
        if (r.mem_write) cells_written++;
        r.cursor_pos    = ADDR_W'(cursor_cell[shown_con]);
        r.start_addr    = ADDR_W'(view_start[shown_con]);
        r.shown_console = shown_con;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Offer one command; return at the edge that accepts it, valid still high.
    task automatic send_cmd(t_cmd cmd, logic [CON_W-1:0] con, logic [CHAR_W-1:0] ch,
                            logic typed, t_res typed_res);
        int   gap;
        t_res predicted;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid   <= 1'b1;
        cmd_if.command <= cmd;
        cmd_if.console <= con;
        cmd_if.ch      <= ch;
        do @(posedge i_clk); while (!cmd_if.ready);
        predicted = apply_console_cmd(cmd, con, ch);
        pending_cell_updates.push_back(typed ? typed_res : predicted);
        items_sent++;
    endtask

    task automatic drain_results();
        cmd_if.valid <= 1'b0;
        while (pending_cell_updates.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_attr(logic [ATTR_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        attr_byte = value;
    endtask

    // One burst of related commands on one console.
    task automatic run_burst();
        int               kind;
        int               len;
        logic [CON_W-1:0] con;
        kind = $urandom_range(0, 99);
        con  = CON_W'($urandom_range(0, CONSOLES - 1));
        if (kind < 30) begin
            len = $urandom_range(1, 40);
            repeat (len) send_cmd(CMD_PUT, con, CHAR_W'($urandom), 1'b0, '0);
        end else if (kind < 50) begin
            len = $urandom_range(1, 20);
            repeat (len) send_cmd(CMD_PUT, con, NEWLINE_BYTE, 1'b0, '0);
        end else if (kind < 60) begin
            len = $urandom_range(1, 10);
            repeat (len) send_cmd(CMD_PUT, con, BACKSPACE_BYTE, 1'b0, '0);
        end else if (kind < 70) begin
            len = $urandom_range(1, 30);
            repeat (len) send_cmd(CMD_SCROLL_UP, con, CHAR_W'($urandom), 1'b0, '0);
        end else if (kind < 80) begin
            len = $urandom_range(1, 30);
            repeat (len) send_cmd(CMD_SCROLL_DOWN, con, CHAR_W'($urandom), 1'b0, '0);
        end else if (kind < 90) begin
            send_cmd(CMD_SELECT, con, CHAR_W'($urandom), 1'b0, '0);
        end else begin
            send_cmd(t_cmd'($urandom_range(0, 3)), con, CHAR_W'($urandom), 1'b0, '0);
        end
    endtask

    initial begin : result_sink
        int   wait_cycles;
        t_res want;
        t_res got;
        res_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (results_seen == HOLD_AT) wait_cycles = HOLD_CYCLES;
            else if (no_idle) wait_cycles = 0;
            else wait_cycles = $urandom_range(0, MAX_GAP);
            if (wait_cycles > 0) begin
                res_if.ready <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!res_if.valid);
            results_seen++;
            got = '{res_if.mem_write, res_if.mem_addr, res_if.mem_char, res_if.mem_attr,
                    res_if.display_update, res_if.cursor_pos, res_if.start_addr,
                    res_if.shown_console};
            if (pending_cell_updates.size() == 0) begin
                $error("result %0d arrived with nothing pending", results_seen);
                mismatches++;
            end else begin
                want = pending_cell_updates.pop_front();
                check_field("mem_write", want.mem_write, got.mem_write);
                check_field("mem_addr", want.mem_addr, got.mem_addr);
                check_field("mem_char", want.mem_char, got.mem_char);
                check_field("mem_attr", want.mem_attr, got.mem_attr);
                check_field("display_update", want.display_update, got.display_update);
                check_field("cursor_pos", want.cursor_pos, got.cursor_pos);
                check_field("start_addr", want.start_addr, got.start_addr);
                check_field("shown_console", want.shown_console, got.shown_console);
            end
        end
    end

    initial begin : stall_watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) || i_cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $error("no item moved for %0d cycles", STALL_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        logic [ATTR_W-1:0] phase_attr [PHASES];
        logic [ATTR_W-1:0] attr_value;
        int                target;

        cmd_if.valid   <= 1'b0;
        cmd_if.command <= CMD_PUT;
        cmd_if.console <= '0;
        cmd_if.ch      <= '0;
        i_cfg_we       <= 1'b0;
        i_cfg_wdata    <= '0;
        i_rst_n        <= 1'b0;

        for (int c = 0; c < CONSOLES; c++) begin
            cursor_cell[c] = c * REGION_CELLS;
            view_start[c]  = c * REGION_CELLS;
        end
        shown_con  = '0;
        attr_byte  = ATTR_RESET;
        phase_attr = '{8'h00, 8'hFF, 8'h5A, 8'h81, 8'h00};
        no_idle    = 1'b0;

        // Rows with typed results follow from reset state at a glance.
        directed_rows = '{
            '{CMD_SELECT, 2'd0, 8'd0, 1'b1,
              '{1'b0, 14'd0, 8'd0, 8'd0, 1'b1, 14'd0, 14'd0, 2'd0}},
            '{CMD_PUT, 2'd0, BACKSPACE_BYTE, 1'b1,
              '{1'b0, 14'd0, 8'd0, 8'd0, 1'b1, 14'd0, 14'd0, 2'd0}},
            '{CMD_SCROLL_UP, 2'd0, 8'd0, 1'b1,
              '{1'b0, 14'd0, 8'd0, 8'd0, 1'b1, 14'd0, 14'd0, 2'd0}},
            '{CMD_PUT, 2'd0, 8'd65, 1'b1,
              '{1'b1, 14'd0, 8'd65, 8'd7, 1'b1, 14'd1, 14'd0, 2'd0}},
            '{CMD_PUT, 2'd0, BACKSPACE_BYTE, 1'b1,
              '{1'b1, 14'd0, 8'd32, 8'd7, 1'b1, 14'd0, 14'd0, 2'd0}},
            '{CMD_PUT, 2'd0, 8'hFF, 1'b1,
              '{1'b1, 14'd0, 8'd255, 8'd7, 1'b1, 14'd1, 14'd0, 2'd0}},
            '{CMD_PUT, 2'd0, 8'h00, 1'b1,
              '{1'b1, 14'd1, 8'd0, 8'd7, 1'b1, 14'd2, 14'd0, 2'd0}},
            '{CMD_PUT, 2'd0, NEWLINE_BYTE, 1'b1,
              '{1'b0, 14'd0, 8'd0, 8'd0, 1'b1, 14'd80, 14'd0, 2'd0}},
            '{CMD_PUT, 2'd1, 8'd66, 1'b1,
              '{1'b1, 14'd4000, 8'd66, 8'd7, 1'b0, 14'd80, 14'd0, 2'd0}},
            '{CMD_SCROLL_DOWN, 2'd0, 8'd0, 1'b1,
              '{1'b0, 14'd0, 8'd0, 8'd0, 1'b1, 14'd80, 14'd80, 2'd0}},
            '{CMD_SCROLL_DOWN, 2'd2, 8'd0, 1'b1,
              '{1'b0, 14'd0, 8'd0, 8'd0, 1'b0, 14'd80, 14'd80, 2'd0}},
            '{CMD_SELECT, 2'd3, 8'd0, 1'b1,
              '{1'b0, 14'd0, 8'd0, 8'd0, 1'b1, 14'd12000, 14'd12000, 2'd3}},
            '{CMD_PUT, 2'd3, NEWLINE_BYTE, 1'b1,
              '{1'b0, 14'd0, 8'd0, 8'd0, 1'b1, 14'd12080, 14'd12000, 2'd3}},
            '{CMD_PUT, 2'd3, BACKSPACE_BYTE, 1'b1,
              '{1'b1, 14'd12079, 8'd32, 8'd7, 1'b1, 14'd12079, 14'd12000, 2'd3}},
            '{CMD_SELECT, 2'd2, 8'hFF, 1'b1,
              '{1'b0, 14'd0, 8'd0, 8'd0, 1'b1, 14'd8000, 14'd8080, 2'd2}},
            '{CMD_PUT, 2'd2, 8'd120, 1'b0, '0},
            '{CMD_SCROLL_UP, 2'd2, 8'hAA, 1'b0, '0},
            '{CMD_SCROLL_UP, 2'd2, 8'h55, 1'b0, '0},
            '{CMD_PUT, 2'd1, BACKSPACE_BYTE, 1'b0, '0},
            '{CMD_PUT, 2'd1, NEWLINE_BYTE, 1'b0, '0},
            '{CMD_SELECT, 2'd1, 8'd0, 1'b0, '0},
            '{CMD_PUT, 2'd1, 8'h7F, 1'b0, '0},
            '{CMD_SCROLL_DOWN, 2'd1, 8'd0, 1'b0, '0},
            '{CMD_PUT, 2'd1, NEWLINE_BYTE, 1'b0, '0},
            '{CMD_SELECT, 2'd0, 8'd0, 1'b0, '0}
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_cmd(directed_rows[i].cmd, directed_rows[i].con, directed_rows[i].ch,
                     directed_rows[i].typed, directed_rows[i].want);

        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            attr_value = (p == PHASES - 1) ? ATTR_W'($urandom) : phase_attr[p];
            write_attr(attr_value);
            // one phase runs back to back on both sides
            no_idle = (p == 1);
            target  = items_sent + PHASE_ITEMS;
            while (items_sent < target) run_burst();
        end
        no_idle = 1'b0;
        drain_results();
        repeat (8) @(posedge i_clk);

        $display("Covered %0d commands over %0d attribute settings; %0d results checked.",
                 items_sent, PHASES + 1, results_seen);
        $display("%0d cell writes, %0d commands held at a region edge, %0d mismatches.",
                 cells_written, clamped_cmds, mismatches);
        if (mismatches == 0 && pending_cell_updates.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
